### rtl/core/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
// No dependencies; imported by every module of the block.
package spq_pkg;

   // Operation codes of the request word.
   typedef enum logic [1:0] {
      KIND_ENQUEUE = 2'd0,
      KIND_DEQUEUE = 2'd1,
      KIND_PEEK    = 2'd2,
      KIND_NOP     = 2'd3
   } kind_type;

   // Status codes of the response word.
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_REJECTED = 2'd2,
      STATUS_RESERVED = 2'd3
   } status_type;

   // Control handed from one cell to its upper neighbor.
   typedef struct packed {
      logic valid;  // cell holds an entry
      logic take;   // cell loads a new entry this cycle
   } spq_link_type;

endpackage

### rtl/core/spq_cell.sv
// One slot of the sorted priority queue: priority, payload and valid bit.
// Depends on spq_pkg; instantiated in a row by sorted_priority_queue_core.
module spq_cell import spq_pkg::*; #(
   parameter int PRIORITY_WIDTH = 8,
   parameter int PAYLOAD_WIDTH  = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enq_go,
   input  logic                      deq_go,
   input  logic [PRIORITY_WIDTH-1:0] new_priority,
   input  logic [PAYLOAD_WIDTH-1:0]  new_payload,
   input  spq_link_type              left_link,
   input  logic [PRIORITY_WIDTH-1:0] left_priority,
   input  logic [PAYLOAD_WIDTH-1:0]  left_payload,
   input  logic                      right_valid,
   output spq_link_type              link,
   output logic [PRIORITY_WIDTH-1:0] slot_priority,
   output logic [PAYLOAD_WIDTH-1:0]  slot_payload,
   output logic                      top_hit
);

   logic                      valid_ff, valid_in;
   logic [PRIORITY_WIDTH-1:0] priority_ff, priority_in;
   logic [PAYLOAD_WIDTH-1:0]  payload_ff, payload_in;
   logic                      hit;
   logic                      take;

   // Slot at or past the insertion point, or first free slot.
   assign hit     = valid_ff && (priority_ff <= new_priority);
   assign take    = enq_go && (hit || (!valid_ff && left_link.valid));
   assign top_hit = valid_ff && !right_valid;

   always_comb begin
      valid_in    = valid_ff;
      priority_in = priority_ff;
      payload_in  = payload_ff;
      if (take) begin
         // shift up from below, or drop the new entry in here
         valid_in    = 1'b1;
         priority_in = left_link.take ? left_priority : new_priority;
         payload_in  = left_link.take ? left_payload  : new_payload;
      end else if (deq_go && top_hit) begin
         valid_in    = 1'b0;
         priority_in = '0;
         payload_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      priority_ff <= priority_in;
      payload_ff  <= payload_in;
   end

   assign link.valid    = valid_ff;
   assign link.take     = take;
   assign slot_priority = priority_ff;
   assign slot_payload  = payload_ff;

endmodule

### rtl/core/sorted_priority_queue_core.sv
// Sorted priority queue top level: a row of slot cells plus a response register.
// Depends on spq_pkg and spq_cell.
//
// Bounded priority queue of DEPTH jobs kept sorted by descending priority
// number in a row of cells; slot 0 holds the largest number and the most
// urgent job sits in the highest occupied slot. Every cell compares its own
// entry with an incoming job at once and, together with its lower neighbor,
// decides whether to hold, load the new job, or take its neighbor's entry, so
// a new request word is accepted in every cycle while the response register
// is free or being drained. A response word is registered and appears in the
// cycle after its request is accepted; the request side stalls only while a
// response word waits under stall. Enqueue is rejected when full or when the
// priority is zero; dequeue and peek on an empty queue report empty. Kind
// three does nothing and reports the counts. Reset empties the queue.
module sorted_priority_queue_core import spq_pkg::*; #(
   parameter int  DEPTH          = 16,
   parameter int  PRIORITY_WIDTH = 8,
   parameter int  PAYLOAD_WIDTH  = 32,
   localparam int COUNT_WIDTH    = $clog2(DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_kind,
   input  logic [PRIORITY_WIDTH-1:0] req_job_priority,
   input  logic [PAYLOAD_WIDTH-1:0]  req_job_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [PRIORITY_WIDTH-1:0] rsp_out_priority,
   output logic [PAYLOAD_WIDTH-1:0]  rsp_out_payload,
   output logic [COUNT_WIDTH-1:0]    rsp_entry_count,
   output logic [COUNT_WIDTH-1:0]    rsp_free_slots
);

   localparam logic [COUNT_WIDTH-1:0] FullCount = COUNT_WIDTH'(DEPTH);

   // Stored entry count.
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   // Response register.
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [PRIORITY_WIDTH-1:0] rsp_priority_ff, rsp_priority_in;
   logic [PAYLOAD_WIDTH-1:0]  rsp_payload_ff, rsp_payload_in;
   logic [COUNT_WIDTH-1:0]    rsp_count_ff;
   logic [COUNT_WIDTH-1:0]    rsp_free_ff;

   logic     accept;
   kind_type kind;
   logic     full, empty;
   logic     enq_go, deq_go;

   // Cell row wiring.
   spq_link_type              link   [DEPTH];
   logic [PRIORITY_WIDTH-1:0] cell_pr [DEPTH];
   logic [PAYLOAD_WIDTH-1:0]  cell_pl [DEPTH];
   logic                      top_hit[DEPTH];

   logic [PRIORITY_WIDTH-1:0] top_priority;
   logic [PAYLOAD_WIDTH-1:0]  top_payload;

   // Hold the request side only while a response word waits under stall.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign kind      = kind_type'(req_kind);
   assign full      = (count_ff == FullCount);
   assign empty     = (count_ff == '0);

   assign enq_go = accept && (kind == KIND_ENQUEUE) && !full && (req_job_priority != '0);
   assign deq_go = accept && (kind == KIND_DEQUEUE) && !empty;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_link_type              left_link;
      logic [PRIORITY_WIDTH-1:0] left_pr;
      logic [PAYLOAD_WIDTH-1:0]  left_pl;
      logic                      right_valid;

      if (i == 0) begin : g_bottom
         // Below slot 0 sits a full, idle neighbor.
         assign left_link = '{valid: 1'b1, take: 1'b0};
         assign left_pr   = '0;
         assign left_pl   = '0;
      end else begin : g_mid
         assign left_link = link[i-1];
         assign left_pr   = cell_pr[i-1];
         assign left_pl   = cell_pl[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_valid = 1'b0;
      end else begin : g_inner
         assign right_valid = link[i+1].valid;
      end

      spq_cell #(
         .PRIORITY_WIDTH (PRIORITY_WIDTH),
         .PAYLOAD_WIDTH  (PAYLOAD_WIDTH)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .enq_go        (enq_go),
         .deq_go        (deq_go),
         .new_priority  (req_job_priority),
         .new_payload   (req_job_payload),
         .left_link     (left_link),
         .left_priority (left_pr),
         .left_payload  (left_pl),
         .right_valid   (right_valid),
         .link          (link[i]),
         .slot_priority (cell_pr[i]),
         .slot_payload  (cell_pl[i]),
         .top_hit       (top_hit[i])
      );
   end

   // Exactly one cell flags itself as top when the queue is not empty.
   always_comb begin
      top_priority = '0;
      top_payload  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         top_priority = top_priority | (top_hit[i] ? cell_pr[i] : '0);
         top_payload  = top_payload  | (top_hit[i] ? cell_pl[i] : '0);
      end
   end

   // Next count and response word.
   always_comb begin
      count_in        = count_ff;
      rsp_status_in   = STATUS_OK;
      rsp_priority_in = '0;
      rsp_payload_in  = '0;
      if (enq_go) begin
         count_in = count_ff + 1'b1;
      end else if (deq_go) begin
         count_in = count_ff - 1'b1;
      end

      case (kind)
         KIND_ENQUEUE: begin
            if (!enq_go) begin
               rsp_status_in = STATUS_REJECTED;
            end
         end
         KIND_DEQUEUE, KIND_PEEK: begin
            if (empty) begin
               rsp_status_in = STATUS_EMPTY;
            end else begin
               rsp_priority_in = top_priority;
               rsp_payload_in  = top_payload;
            end
         end
         default: begin
            rsp_status_in = STATUS_OK;
         end
      endcase

      // Drop the response word once taken; load a new one on accept.
      rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_priority_ff <= rsp_priority_in;
         rsp_payload_ff  <= rsp_payload_in;
         rsp_count_ff    <= count_in;
         rsp_free_ff     <= FullCount - count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_priority = rsp_priority_ff;
   assign rsp_out_payload  = rsp_payload_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_free_slots   = rsp_free_ff;

endmodule

### tb/sv/spq_order_checker.sv
// Checker for the sorted priority queue: watches both channels, keeps its own
// copy of the sorted store and compares every response word with its prediction.
// Depends on spq_pkg for the operation and status codes.
module spq_order_checker import spq_pkg::*; #(
   parameter int DEPTH          = 16,
   parameter int PRIORITY_WIDTH = 8,
   parameter int PAYLOAD_WIDTH  = 32,
   parameter int COUNT_WIDTH    = $clog2(DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [1:0]                req_kind,
   input  logic [PRIORITY_WIDTH-1:0] req_job_priority,
   input  logic [PAYLOAD_WIDTH-1:0]  req_job_payload,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [1:0]                rsp_status,
   input  logic [PRIORITY_WIDTH-1:0] rsp_out_priority,
   input  logic [PAYLOAD_WIDTH-1:0]  rsp_out_payload,
   input  logic [COUNT_WIDTH-1:0]    rsp_entry_count,
   input  logic [COUNT_WIDTH-1:0]    rsp_free_slots,
   output int                        mismatch_count,
   output int                        outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_CAP = 100;

   typedef struct packed {
      logic [1:0]                status;
      logic [PRIORITY_WIDTH-1:0] job_priority;
      logic [PAYLOAD_WIDTH-1:0]  job_payload;
      logic [COUNT_WIDTH-1:0]    entry_count;
      logic [COUNT_WIDTH-1:0]    free_slots;
   } queue_answer_type;

   // Shadow store, sorted by descending priority number; most urgent on top.
   logic [PRIORITY_WIDTH-1:0] shadow_priority [DEPTH];
   logic [PAYLOAD_WIDTH-1:0]  shadow_payload [DEPTH];
   int                        shadow_count;

   queue_answer_type answer_q [$];

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("[%0t] queue mismatch: %s", $realtime, what);
   endtask

   function automatic string show(input queue_answer_type a);
      return $sformatf("status=%0d pri=%0d pay=%h count=%0d free=%0d",
                       a.status, a.job_priority, a.job_payload,
                       a.entry_count, a.free_slots);
   endfunction

   // Apply one request word to the shadow store and return the answer it earns.
   function automatic queue_answer_type apply_queue_op(
      input logic [1:0]                kind,
      input logic [PRIORITY_WIDTH-1:0] job_priority,
      input logic [PAYLOAD_WIDTH-1:0]  job_payload
   );
      queue_answer_type answer;
      int               slot;
      int               top;
      answer = '0;
      answer.status = STATUS_OK;
      case (kind)
         KIND_ENQUEUE: begin
            if (shadow_count >= DEPTH || job_priority == '0) begin
               answer.status = STATUS_REJECTED;
            end else begin
               slot = shadow_count;
               for (int i = 0; i < shadow_count; i++) begin
                  if (shadow_priority[i] <= job_priority) begin
                     slot = i;
                     break;
                  end
               end
               for (int i = shadow_count; i > slot; i--) begin
                  shadow_priority[i] = shadow_priority[i-1];
                  shadow_payload[i]  = shadow_payload[i-1];
               end
               shadow_priority[slot] = job_priority;
               shadow_payload[slot]  = job_payload;
               shadow_count++;
            end
         end
         KIND_DEQUEUE, KIND_PEEK: begin
            if (shadow_count == 0) begin
               answer.status = STATUS_EMPTY;
            end else begin
               top = shadow_count - 1;
               answer.job_priority = shadow_priority[top];
               answer.job_payload  = shadow_payload[top];
               if (kind == KIND_DEQUEUE) begin
                  shadow_priority[top] = '0;
                  shadow_payload[top]  = '0;
                  shadow_count--;
               end
            end
         end
         default: ;
      endcase
      answer.entry_count = COUNT_WIDTH'(shadow_count);
      answer.free_slots  = COUNT_WIDTH'(DEPTH - shadow_count);
      return answer;
   endfunction

   always @(posedge clock) begin : watch_words
      queue_answer_type wanted;
      queue_answer_type seen;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            shadow_priority[i] = '0;
            shadow_payload[i]  = '0;
         end
         shadow_count = 0;
         answer_q.delete();
      end else begin
         // Check the response first: it always belongs to an older request.
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_status, rsp_out_priority, rsp_out_payload,
                    rsp_entry_count, rsp_free_slots};
            if (answer_q.size() == 0) begin
               report_mismatch({"unexpected word: ", show(seen)});
            end else begin
               wanted = answer_q.pop_front();
               if (seen !== wanted)
                  report_mismatch({"got ", show(seen), " want ", show(wanted)});
            end
         end
         if (req_valid && !req_stall)
            answer_q.push_back(apply_queue_op(req_kind, req_job_priority, req_job_payload));
      end
      outstanding <= answer_q.size();
   end

endmodule

### tb/sv/testbench.sv
// Top of the sorted priority queue testbench: clock, reset, request stimulus,
// response-side stall and the verdict. Depends on spq_pkg, the
// sorted_priority_queue_core RTL and spq_order_checker.
module testbench import spq_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH          = 16;
   localparam int PRIORITY_WIDTH = 8;
   localparam int PAYLOAD_WIDTH  = 32;
   localparam int COUNT_WIDTH    = $clog2(DEPTH + 1);
   localparam int PHASES         = 10;
   localparam int PHASE_WORDS    = 75;

   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      req_valid        = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_kind         = KIND_NOP;
   logic [PRIORITY_WIDTH-1:0] req_job_priority = '0;
   logic [PAYLOAD_WIDTH-1:0]  req_job_payload  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall        = 1'b0;
   logic [1:0]                rsp_status;
   logic [PRIORITY_WIDTH-1:0] rsp_out_priority;
   logic [PAYLOAD_WIDTH-1:0]  rsp_out_payload;
   logic [COUNT_WIDTH-1:0]    rsp_entry_count;
   logic [COUNT_WIDTH-1:0]    rsp_free_slots;

   int mismatch_count;
   int outstanding;

   // Idle controls: when steady, that side never inserts gaps or stalls.
   bit sender_steady   = 1'b0;
   bit receiver_steady = 1'b0;
   int stall_left      = 0;
   int stall_draw;

   sorted_priority_queue_core #(
      .DEPTH          (DEPTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH),
      .PAYLOAD_WIDTH  (PAYLOAD_WIDTH)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_job_priority (req_job_priority),
      .req_job_payload  (req_job_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_priority (rsp_out_priority),
      .rsp_out_payload  (rsp_out_payload),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_free_slots   (rsp_free_slots)
   );

   spq_order_checker #(
      .DEPTH          (DEPTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH),
      .PAYLOAD_WIDTH  (PAYLOAD_WIDTH)
   ) checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_job_priority (req_job_priority),
      .req_job_payload  (req_job_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_priority (rsp_out_priority),
      .rsp_out_payload  (rsp_out_payload),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_free_slots   (rsp_free_slots),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run.
   initial begin
      #2ms;
      $display("Simulation FAILED");
      $finish;
   end

   // Response side: after every accepted word, draw a random stall, possibly none,
   // and hold rsp_stall high for its length before taking the next word.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end else if (rsp_valid && !rsp_stall) begin
         stall_draw = receiver_steady ? 0 : $urandom_range(0, 5);
         stall_left <= stall_draw;
         rsp_stall  <= (stall_draw != 0);
      end
   end

   // Present one request word after a random gap and wait until it is taken.
   // Valid stays high between back-to-back words, so it gets one update per edge unless req_stall holds it.
   task automatic send_word(input kind_type kind,
                            input logic [PRIORITY_WIDTH-1:0] job_priority,
                            input logic [PAYLOAD_WIDTH-1:0] job_payload);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_job_priority <= job_priority;
      req_job_payload  <= job_payload;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid and hold off until every outstanding response has come back.
   task automatic hold_until_answered();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Numbers from one up to the spread (small spreads make equal priorities collide), plus zero and the extremes.
   function automatic logic [PRIORITY_WIDTH-1:0] draw_priority(input int spread);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 5)
         return '0;
      if (pick < 9)
         return pick[0] ? PRIORITY_WIDTH'(1) : '1;
      return PRIORITY_WIDTH'($urandom_range(1, spread));
   endfunction

   // Pick an operation: enqueue share set by the phase, a few no-ops,
   // and dequeue favored over peek so the queue actually drains.
   function automatic kind_type draw_kind(input int enqueue_pct);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 3)
         return KIND_NOP;
      if (pick < 3 + enqueue_pct)
         return KIND_ENQUEUE;
      return ($urandom_range(0, 99) < 65) ? KIND_DEQUEUE : KIND_PEEK;
   endfunction

   initial begin : stimulus
      int enqueue_pct;
      int spread;
      int mode;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty queue, invalid priority, unused kind, then fill with
      // extremes and ties, overflow, peek, and dequeue the two most urgent entries.
      send_word(KIND_DEQUEUE, '0, '0);
      send_word(KIND_PEEK, '1, '1);
      send_word(KIND_ENQUEUE, '0, '1);
      send_word(KIND_NOP, '1, '1);
      send_word(KIND_ENQUEUE, '1, '0);
      send_word(KIND_ENQUEUE, PRIORITY_WIDTH'(1), '1);
      for (int i = 0; i < DEPTH - 2; i++)
         send_word(KIND_ENQUEUE, PRIORITY_WIDTH'(1 + (i % 4)), PAYLOAD_WIDTH'(32'hA000 + i));
      send_word(KIND_ENQUEUE, PRIORITY_WIDTH'(1), 32'h5555_AAAA);
      send_word(KIND_PEEK, '0, '0);
      send_word(KIND_NOP, '0, '0);
      send_word(KIND_DEQUEUE, '0, '0);
      send_word(KIND_DEQUEUE, '0, '0);
      hold_until_answered();

      // Random phases: alternate fill-heavy and drain-heavy mixes so the queue
      // swings between empty and full, with varied priority spread and idling.
      for (int phase = 0; phase < PHASES; phase++) begin
         enqueue_pct = (phase % 2 == 0) ? $urandom_range(55, 85) : $urandom_range(10, 40);
         case ($urandom_range(0, 2))
            0: spread = 3;
            1: spread = 16;
            default: spread = (1 << PRIORITY_WIDTH) - 1;
         endcase
         // Walk all four idle combinations, including stretches with none.
         mode = phase % 4;
         sender_steady   = mode[0];
         receiver_steady = mode[1];
         for (int n = 0; n < PHASE_WORDS; n++) begin
            send_word(draw_kind(enqueue_pct), draw_priority(spread), $urandom());
            if ($urandom_range(0, 99) == 0)
               hold_until_answered();
         end
         if (phase % 2 == 1)
            hold_until_answered();
      end

      // Drain: wait for every response, then keep the clock running to catch stray words.
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
      hold_until_answered();
      repeat (5) @(posedge clock);

      if (mismatch_count == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_core.sv
tb/sv/spq_order_checker.sv
tb/sv/testbench.sv
